// File: hw/rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg: types and constants for the request command parser
// Item structs, phase/kind/error codes and the framing characters.
// ----------------------------------------------------------------------------
package rcp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  typedef enum logic [1:0] {
    KIND_ARG_START = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_COMPLETE  = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_ARRAY      = 3'd0,
    ERR_COUNT_NO_CRLF = 3'd1,
    ERR_BAD_COUNT     = 3'd2,
    ERR_EXPECT_BULK   = 3'd3,
    ERR_LEN_NO_CRLF   = 3'd4,
    ERR_BAD_LEN       = 3'd5,
    ERR_TRUNCATED     = 3'd6
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [30:0] arg_number;
    logic [30:0] arg_length;
    logic [30:0] arg_total;
    logic [31:0] consumed;
    err_e        error_code;
    logic        run_last;
  } out_t;

  typedef enum logic [2:0] {
    PH_STAR    = 3'd0,
    PH_COUNT   = 3'd1,
    PH_DOLLAR  = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  // number field flags
  typedef struct packed {
    logic neg;
    logic dig;
    logic fin;
    logic ovf;
  } nflags_t;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int unsigned FIFO_DEPTH = 4;

endpackage

// File: hw/rtl/resp_command_parser.sv
// Results of a byte are registered into the result queue when the byte is accepted.
// Throughput: one byte per cycle unless the input stalls, which it does while the
// four-entry result queue holds more than two words; the single-word output port
// drains one word at a time, so bytes with two results or a stalled output fill it.
// Reset: asynchronous, active low; parser state returns to awaiting the array
// marker and the result queue empties. State also returns there on every buffer end.
// ----------------------------------------------------------------------------
// resp_command_parser: streaming parser for array-of-bulk-string requests
// Decodes one byte per cycle while the input is not stalled, and queues argument,
// payload, completion and error words.
// ----------------------------------------------------------------------------
module resp_command_parser #(
  parameter int unsigned NUMBER_BITS   = 31,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rcp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rcp_pkg::out_t out_data_o
);

  localparam int unsigned NB = NUMBER_BITS;
  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned EW = ((PB > 32) ? PB : 32) + 1;
  localparam logic [NB-1:0] NMAX = {NB{1'b1}};
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};
  localparam int unsigned AW = $clog2(rcp_pkg::FIFO_DEPTH);

  // parser state
  rcp_pkg::phase_e  phase_q, phase_d;
  logic             saw_cr_q, saw_cr_d;
  rcp_pkg::nflags_t nf_q, nf_d;
  logic [NB-1:0]    nval_q, nval_d;
  logic [NB-1:0]    args_q, args_d;
  logic [NB-1:0]    argc_q, argc_d;
  logic [NB-1:0]    bytes_q, bytes_d;
  logic [1:0]       trail_q, trail_d;
  logic [PB-1:0]    pos_q, pos_d;

  // result queue
  rcp_pkg::out_t    fifo_q [rcp_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      cnt_q;

  logic             in_acc, out_acc;
  logic [7:0]       b;
  logic             last;
  logic             is_digit;
  logic [NB+3:0]    prod;
  logic             bad;
  logic             fin_arg;
  logic [NB-1:0]    argc_inc, args_dec, bytes_dec;
  logic [1:0]       trail_dec;
  logic [EW-1:0]    pos_ext, pos_ext2;
  logic [31:0]      cons0, cons2;
  rcp_pkg::out_t    res_c [2];
  logic [1:0]       n_c;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign b       = in_data_i.data_byte;
  assign last    = in_data_i.buffer_end;

  assign in_stall_o  = cnt_q > (AW + 1)'(rcp_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // decimal accumulate: value * 10 + digit, checked against the field limit
  assign is_digit = (b >= rcp_pkg::CHAR_ZERO) && (b <= rcp_pkg::CHAR_NINE);
  assign prod     = ({4'b0, nval_q} << 3) + ({4'b0, nval_q} << 1)
                  + (NB + 4)'(b[3:0]);

  assign argc_inc  = argc_q + NB'(1);
  assign args_dec  = args_q - NB'(1);
  assign bytes_dec = bytes_q - NB'(1);
  assign trail_dec = (trail_q != 2'd0) ? trail_q - 2'd1 : trail_q;

  assign pos_d    = (pos_q == PMAX) ? pos_q : pos_q + PB'(1);
  assign pos_ext  = EW'(pos_d);
  assign pos_ext2 = pos_ext + EW'(2);
  assign cons0    = (|pos_ext[EW-1:32])  ? '1 : pos_ext[31:0];
  assign cons2    = (|pos_ext2[EW-1:32]) ? '1 : pos_ext2[31:0];

  assign bad = !nf_q.dig || nf_q.ovf || (nf_q.neg && (nval_q != '0));

  always_comb begin
    phase_d  = phase_q;
    saw_cr_d = saw_cr_q;
    nf_d     = nf_q;
    nval_d   = nval_q;
    args_d   = args_q;
    argc_d   = argc_q;
    bytes_d  = bytes_q;
    trail_d  = trail_q;
    fin_arg  = 1'b0;
    res_c[0] = '0;
    res_c[1] = '0;
    n_c      = 2'd0;

    case (phase_q)
      rcp_pkg::PH_STAR: begin
        if (b == rcp_pkg::CHAR_STAR) begin
          phase_d  = rcp_pkg::PH_COUNT;
          nf_d     = '0;
          nval_d   = '0;
          saw_cr_d = 1'b0;
        end else begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_NO_ARRAY;
          n_c     = n_c + 2'd1;
          phase_d = rcp_pkg::PH_DONE;
        end
      end
      rcp_pkg::PH_COUNT, rcp_pkg::PH_LEN: begin
        if ((b == rcp_pkg::CHAR_LF) && saw_cr_q) begin
          if (bad) begin
            res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
            res_c[n_c[0]].error_code = (phase_q == rcp_pkg::PH_COUNT) ?
                                       rcp_pkg::ERR_BAD_COUNT : rcp_pkg::ERR_BAD_LEN;
            n_c     = n_c + 2'd1;
            phase_d = rcp_pkg::PH_DONE;
          end else if (phase_q == rcp_pkg::PH_COUNT) begin
            args_d = nval_q;
            argc_d = '0;
            if (nval_q == '0) begin
              res_c[n_c[0]].kind      = rcp_pkg::KIND_COMPLETE;
              res_c[n_c[0]].arg_total = '0;
              res_c[n_c[0]].consumed  = cons0;
              n_c     = n_c + 2'd1;
              phase_d = rcp_pkg::PH_DONE;
            end else begin
              phase_d = rcp_pkg::PH_DOLLAR;
            end
          end else begin
            bytes_d = nval_q;
            res_c[n_c[0]].kind       = rcp_pkg::KIND_ARG_START;
            res_c[n_c[0]].arg_number = 31'(argc_q);
            res_c[n_c[0]].arg_length = 31'(nval_q);
            n_c = n_c + 2'd1;
            if (nval_q == '0) fin_arg = 1'b1;
            else phase_d = rcp_pkg::PH_PAYLOAD;
          end
        end else begin
          if (!nf_q.fin) begin
            if (is_digit) begin
              nf_d.dig = 1'b1;
              if (!nf_q.ovf) begin
                if (|prod[NB+3:NB]) begin
                  nf_d.ovf = 1'b1;
                  nval_d   = NMAX;
                end else begin
                  nval_d = prod[NB-1:0];
                end
              end
            end else if ((b == rcp_pkg::CHAR_MINUS) && (nf_q == '0)) begin
              nf_d.neg = 1'b1;
            end else begin
              nf_d.fin = 1'b1;
            end
          end
          saw_cr_d = (b == rcp_pkg::CHAR_CR);
        end
      end
      rcp_pkg::PH_DOLLAR: begin
        if (b == rcp_pkg::CHAR_DOLLAR) begin
          phase_d  = rcp_pkg::PH_LEN;
          nf_d     = '0;
          nval_d   = '0;
          saw_cr_d = 1'b0;
        end else begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_EXPECT_BULK;
          n_c     = n_c + 2'd1;
          phase_d = rcp_pkg::PH_DONE;
        end
      end
      rcp_pkg::PH_PAYLOAD: begin
        res_c[n_c[0]].kind       = rcp_pkg::KIND_PAYLOAD;
        res_c[n_c[0]].payload    = b;
        res_c[n_c[0]].arg_number = 31'(argc_q);
        n_c     = n_c + 2'd1;
        bytes_d = bytes_dec;
        if (bytes_dec == '0) fin_arg = 1'b1;
      end
      rcp_pkg::PH_TRAILER: begin
        trail_d = trail_dec;
        if (trail_dec == 2'd0) phase_d = rcp_pkg::PH_DOLLAR;
      end
      default: begin
      end
    endcase

    // argument finished: either the command is complete or skip the two trailer bytes
    if (fin_arg) begin
      argc_d = argc_inc;
      args_d = args_dec;
      if (args_dec == '0) begin
        res_c[n_c[0]].kind      = rcp_pkg::KIND_COMPLETE;
        res_c[n_c[0]].arg_total = 31'(argc_inc);
        res_c[n_c[0]].consumed  = cons2;
        n_c     = n_c + 2'd1;
        phase_d = rcp_pkg::PH_DONE;
      end else begin
        phase_d = rcp_pkg::PH_TRAILER;
        trail_d = 2'd2;
      end
    end

    if (last) begin
      case (phase_d)
        rcp_pkg::PH_COUNT: begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_COUNT_NO_CRLF;
          n_c = n_c + 2'd1;
        end
        rcp_pkg::PH_LEN: begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_LEN_NO_CRLF;
          n_c = n_c + 2'd1;
        end
        rcp_pkg::PH_PAYLOAD: begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_TRUNCATED;
          n_c = n_c + 2'd1;
        end
        rcp_pkg::PH_DOLLAR, rcp_pkg::PH_TRAILER: begin
          res_c[n_c[0]].kind       = rcp_pkg::KIND_ERROR;
          res_c[n_c[0]].error_code = rcp_pkg::ERR_EXPECT_BULK;
          n_c = n_c + 2'd1;
        end
        default: begin
        end
      endcase
      // buffer boundary: back to the start of a new request
      phase_d  = rcp_pkg::PH_STAR;
      saw_cr_d = 1'b0;
      nf_d     = '0;
      nval_d   = '0;
      args_d   = '0;
      argc_d   = '0;
      bytes_d  = '0;
      trail_d  = 2'd0;
    end

    if (n_c == 2'd2) res_c[1].run_last = 1'b1;
    else if (n_c == 2'd1) res_c[0].run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rcp_pkg::PH_STAR;
      saw_cr_q <= 1'b0;
      nf_q     <= '0;
      nval_q   <= '0;
      args_q   <= '0;
      argc_q   <= '0;
      bytes_q  <= '0;
      trail_q  <= 2'd0;
      pos_q    <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      saw_cr_q <= saw_cr_d;
      nf_q     <= nf_d;
      nval_q   <= nval_d;
      args_q   <= args_d;
      argc_q   <= argc_d;
      bytes_q  <= bytes_d;
      trail_q  <= trail_d;
      pos_q    <= last ? '0 : pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) wr_ptr_q <= wr_ptr_q + AW'(n_c);
      if (out_acc) rd_ptr_q <= rd_ptr_q + AW'(1);
      cnt_q <= cnt_q + (in_acc ? (AW + 1)'(n_c) : '0) - (AW + 1)'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (n_c != 2'd0)) fifo_q[wr_ptr_q] <= res_c[0];
    if (in_acc && (n_c == 2'd2)) fifo_q[wr_ptr_q + AW'(1)] <= res_c[1];
  end

`ifndef NO_ASSERTIONS
  // queue never holds more words than it has entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW + 1)'(rcp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // occupancy only moves on a handshake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && !out_acc) |=> $stable(cnt_q))
    else $error("queue count moved without a handshake");

  // every buffer end returns the parser to the array marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> (phase_q == rcp_pkg::PH_STAR))
    else $error("parser not restarted after buffer end");

  // payload words only come out of the payload phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (n_c != 2'd0) && (res_c[0].kind == rcp_pkg::KIND_PAYLOAD))
      |-> (phase_q == rcp_pkg::PH_PAYLOAD))
    else $error("payload word outside payload phase");
`endif

endmodule

// File: test/rcp_parse_scoreboard.sv
// ----------------------------------------------------------------------------
// rcp_parse_scoreboard: result predictor and comparator for the command parser
// Watches both channels, parses every accepted byte with its own parser model
// and checks each result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module rcp_parse_scoreboard (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rcp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rcp_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            words_seen_o,
  output int            completions_o,
  output int            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] FIELD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;

  // parser model state
  rcp_pkg::phase_e  ph;
  logic             saw_cr;
  rcp_pkg::nflags_t nflags;
  logic [31:0]      nvalue;
  logic [30:0]      args_left;
  logic [30:0]      arg_idx;
  logic [30:0]      bytes_left;
  logic [1:0]       trailer_left;
  logic [31:0]      byte_pos;

  rcp_pkg::out_t step_words [2];
  int            step_count;
  rcp_pkg::out_t expected_words_q [$];
  rcp_pkg::out_t want;

  int mismatch_count = 0;
  int words_seen     = 0;
  int completions    = 0;
  int errors         = 0;

  assign fail_count_o  = mismatch_count;
  assign words_seen_o  = words_seen;
  assign completions_o = completions;
  assign errors_o      = errors;

  function automatic void clear_number();
    nflags = '0;
    nvalue = '0;
    saw_cr = 1'b0;
  endfunction

  function automatic void reset_parse_state();
    ph = rcp_pkg::PH_STAR;
    clear_number();
    args_left    = '0;
    arg_idx      = '0;
    bytes_left   = '0;
    trailer_left = '0;
    byte_pos     = '0;
  endfunction

  // error code field is zero (ERR_NO_ARRAY) on every non-error word
  function automatic void post_word(rcp_pkg::kind_e k, logic [7:0] pl, logic [30:0] num,
                                    logic [30:0] len, logic [30:0] total,
                                    logic [31:0] used, rcp_pkg::err_e code);
    rcp_pkg::out_t w;
    if (step_count < 2) begin
      w.kind       = k;
      w.payload    = pl;
      w.arg_number = num;
      w.arg_length = len;
      w.arg_total  = total;
      w.consumed   = used;
      w.error_code = code;
      w.run_last   = 1'b0;
      step_words[step_count] = w;
      step_count++;
    end
  endfunction

  function automatic void post_error(rcp_pkg::err_e code);
    post_word(rcp_pkg::KIND_ERROR, '0, '0, '0, '0, '0, code);
    ph = rcp_pkg::PH_DONE;
  endfunction

  function automatic void post_complete(logic [31:0] used);
    post_word(rcp_pkg::KIND_COMPLETE, '0, '0, '0, arg_idx, used, rcp_pkg::ERR_NO_ARRAY);
    ph = rcp_pkg::PH_DONE;
  endfunction

  function automatic void feed_number(logic [7:0] b);
    logic [35:0] grown;
    if (!nflags.fin) begin
      if (b >= rcp_pkg::CHAR_ZERO && b <= rcp_pkg::CHAR_NINE) begin
        nflags.dig = 1'b1;
        if (!nflags.ovf) begin
          grown = 36'(nvalue) * 36'd10 + 36'(b - rcp_pkg::CHAR_ZERO);
          if (grown > 36'(FIELD_MAX)) begin
            nflags.ovf = 1'b1;
            nvalue     = FIELD_MAX;
          end else begin
            nvalue = grown[31:0];
          end
        end
      end else if (b == rcp_pkg::CHAR_MINUS && nflags == '0) begin
        nflags.neg = 1'b1;
      end else begin
        nflags.fin = 1'b1;
      end
    end
  endfunction

  function automatic logic number_bad();
    return !nflags.dig || nflags.ovf || (nflags.neg && nvalue != '0);
  endfunction

  // consumed count includes the two unchecked bytes after the last payload
  function automatic void finish_arg();
    logic [32:0] used;
    arg_idx   = arg_idx + 31'd1;
    args_left = args_left - 31'd1;
    if (args_left == '0) begin
      used = {1'b0, byte_pos} + 33'd2;
      post_complete(used[32] ? POS_MAX : used[31:0]);
    end else begin
      ph           = rcp_pkg::PH_TRAILER;
      trailer_left = 2'd2;
    end
  endfunction

  function automatic void predict_parse_step(rcp_pkg::in_t w);
    logic [7:0] b;
    b          = w.data_byte;
    step_count = 0;
    if (byte_pos != POS_MAX) byte_pos++;

    case (ph)
      rcp_pkg::PH_STAR: begin
        if (b == rcp_pkg::CHAR_STAR) begin
          ph = rcp_pkg::PH_COUNT;
          clear_number();
        end else begin
          post_error(rcp_pkg::ERR_NO_ARRAY);
        end
      end
      rcp_pkg::PH_COUNT, rcp_pkg::PH_LEN: begin
        if (b == rcp_pkg::CHAR_LF && saw_cr) begin
          if (number_bad()) begin
            if (ph == rcp_pkg::PH_COUNT) post_error(rcp_pkg::ERR_BAD_COUNT);
            else post_error(rcp_pkg::ERR_BAD_LEN);
          end else if (ph == rcp_pkg::PH_COUNT) begin
            args_left = nvalue[30:0];
            arg_idx   = '0;
            if (args_left == '0) post_complete(byte_pos);
            else ph = rcp_pkg::PH_DOLLAR;
          end else begin
            bytes_left = nvalue[30:0];
            post_word(rcp_pkg::KIND_ARG_START, '0, arg_idx, bytes_left, '0, '0,
                      rcp_pkg::ERR_NO_ARRAY);
            if (bytes_left == '0) finish_arg();
            else ph = rcp_pkg::PH_PAYLOAD;
          end
        end else begin
          feed_number(b);
          saw_cr = (b == rcp_pkg::CHAR_CR);
        end
      end
      rcp_pkg::PH_DOLLAR: begin
        if (b == rcp_pkg::CHAR_DOLLAR) begin
          ph = rcp_pkg::PH_LEN;
          clear_number();
        end else begin
          post_error(rcp_pkg::ERR_EXPECT_BULK);
        end
      end
      rcp_pkg::PH_PAYLOAD: begin
        post_word(rcp_pkg::KIND_PAYLOAD, b, arg_idx, '0, '0, '0, rcp_pkg::ERR_NO_ARRAY);
        bytes_left = bytes_left - 31'd1;
        if (bytes_left == '0) finish_arg();
      end
      rcp_pkg::PH_TRAILER: begin
        if (trailer_left != '0) trailer_left--;
        if (trailer_left == '0) ph = rcp_pkg::PH_DOLLAR;
      end
      default: ;
    endcase

    // buffer end: report an unfinished parse, then restart the parse state
    if (w.buffer_end) begin
      case (ph)
        rcp_pkg::PH_COUNT:   post_error(rcp_pkg::ERR_COUNT_NO_CRLF);
        rcp_pkg::PH_LEN:     post_error(rcp_pkg::ERR_LEN_NO_CRLF);
        rcp_pkg::PH_PAYLOAD: post_error(rcp_pkg::ERR_TRUNCATED);
        rcp_pkg::PH_DOLLAR, rcp_pkg::PH_TRAILER: post_error(rcp_pkg::ERR_EXPECT_BULK);
        default: ;
      endcase
      reset_parse_state();
    end

    if (step_count > 0) step_words[step_count - 1].run_last = 1'b1;
    for (int i = 0; i < step_count; i++) expected_words_q.push_back(step_words[i]);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_parse_state();
      expected_words_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_parse_step(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        words_seen++;
        if (expected_words_q.size() == 0) begin
          $display("%0d ns: result word with none expected, actual kind %0d",
                   $time, out_data_i.kind);
          mismatch_count++;
        end else begin
          want = expected_words_q.pop_front();
          compare_field("kind",       want.kind,       out_data_i.kind);
          compare_field("payload",    want.payload,    out_data_i.payload);
          compare_field("arg_number", want.arg_number, out_data_i.arg_number);
          compare_field("arg_length", want.arg_length, out_data_i.arg_length);
          compare_field("arg_total",  want.arg_total,  out_data_i.arg_total);
          compare_field("consumed",   want.consumed,   out_data_i.consumed);
          compare_field("error_code", want.error_code, out_data_i.error_code);
          compare_field("run_last",   want.run_last,   out_data_i.run_last);
          if (want.kind == rcp_pkg::KIND_COMPLETE) completions++;
          else if (want.kind == rcp_pkg::KIND_ERROR) errors++;
        end
      end
      pending_o <= expected_words_q.size();
    end
  end

endmodule

// File: test/resp_command_parser_test.sv
// ----------------------------------------------------------------------------
// resp_command_parser_test: stimulus and verdict for the command parser
// Sends directed request buffers, then random well-formed, cut-short, mutated,
// overlong-length and noise buffers with bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module resp_command_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_TARGET = 1750;
  localparam int unsigned PAUSE_EVERY = 400;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_BURSTY
  } stall_mode_e;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  rcp_pkg::in_t   in_word   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rcp_pkg::out_t  out_word;

  int fail_count;
  int pending;
  int words_seen;
  int completions;
  int errors;

  int unsigned burst_left   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned buffers_sent = 0;
  logic [7:0]  req_q [$];

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  logic [31:0] tick       = '0;

  resp_command_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word)
  );

  rcp_parse_scoreboard u_parse_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .words_seen_o  (words_seen),
    .completions_o (completions),
    .errors_o      (errors)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // output stall runs in stretches, each with its own pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 120);
    end
    stall_left--;
    tick++;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
      STALL_HEAVY:  out_stall <= (tick % 5) != 0;
      default:      out_stall <= (tick[3:2] == 2'b11);
    endcase
  end

  // '|' stands for CR LF
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "|") begin
        req_q.push_back(rcp_pkg::CHAR_CR);
        req_q.push_back(rcp_pkg::CHAR_LF);
      end else begin
        req_q.push_back(s[i]);
      end
    end
  endfunction

  // count or length field, mostly plain, sometimes with padding or junk
  function automatic void add_field(int unsigned v);
    int unsigned style;
    style = $urandom_range(0, 9);
    if (v == 0 && style == 0) begin
      add_text("-0");
    end else begin
      if (style == 1) add_text("00");
      add_text($sformatf("%0d", v));
      if (style == 2) add_text(" x");
    end
    add_text("|");
  endfunction

  function automatic void add_request();
    int unsigned argc;
    int unsigned len;
    argc = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
    req_q.push_back(rcp_pkg::CHAR_STAR);
    add_field(argc);
    repeat (argc) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 10);
      req_q.push_back(rcp_pkg::CHAR_DOLLAR);
      add_field(len);
      repeat (len) req_q.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        req_q.push_back(8'($urandom));
        req_q.push_back(8'($urandom));
      end else begin
        add_text("|");
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, buffer_end: is_last};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_request();
    for (int i = 0; i < req_q.size(); i++) send_byte(req_q[i], i == req_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic send_text(string s);
    req_q.delete();
    add_text(s);
    send_request();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    int unsigned sel;
    int unsigned keep;
    int unsigned spot;
    int unsigned next_pause;

    next_pause = PAUSE_EVERY;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("*0|");
    send_text("*1|$3|abc|");
    send_text("*2|$0||$1|\377|");
    send_text("x");
    send_text("*");
    send_text("*-0|");
    send_text("*-1|");
    send_text("*|");
    send_text("*2147483648|");
    send_text("*99999999999999|");
    send_text("*1|$2147483647|ab");
    send_text("*3junk|$1|z|");
    send_text("*2147483647|$1|q|");
    send_text("*1|#");
    send_text("*1|$");
    send_text("*1|$x|");
    send_text("*1|$-0||");
    send_text("*1|$5|ab");
    send_text("*1\015\015|$1|q|");
    send_text("*1|$2|ab|zzz");
    send_text("*1|$1|q");
    send_text("*2|$1|q");
    send_text("*1|$0|");
    send_text("*2|$0|");
    send_text("*2--1|$1|-|");
    send_text("*1\n|$1|q|");
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      req_q.delete();
      sel = $urandom_range(0, 99);
      if (sel < 94) begin
        add_request();
        if (sel < 65) begin
          // well-formed; bytes after the completion are ignored
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) req_q.push_back(8'($urandom));
        end else if (sel < 82) begin
          keep = $urandom_range(1, req_q.size() - 1);
          while (req_q.size() > keep) void'(req_q.pop_back());
        end else begin
          spot = $urandom_range(0, req_q.size() - 1);
          case ($urandom_range(0, 5))
            0:       req_q[spot] = rcp_pkg::CHAR_STAR;
            1:       req_q[spot] = rcp_pkg::CHAR_DOLLAR;
            2:       req_q[spot] = rcp_pkg::CHAR_MINUS;
            3:       req_q[spot] = rcp_pkg::CHAR_CR;
            4:       req_q[spot] = rcp_pkg::CHAR_LF;
            default: req_q[spot] = 8'($urandom);
          endcase
        end
      end else if (sel < 97) begin
        // declared length far beyond what the buffer holds, or overflowing
        add_text("*1|$");
        if ($urandom_range(0, 1) == 0)
          add_text($sformatf("%0d", $urandom_range(1000, 32'h7FFF_FFFF)));
        else
          add_text($sformatf("%0d%0d", $urandom_range(3, 9), $urandom));
        add_text("|");
        repeat ($urandom_range(0, 6)) req_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) req_q.push_back(8'($urandom));
      end
      send_request();
      if (bytes_sent >= next_pause) begin
        drain_results();
        next_pause += PAUSE_EVERY;
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d buffers (%0d bytes) of directed and random requests.",
             buffers_sent, bytes_sent);
    $display("Checked %0d result words: %0d completions, %0d errors.",
             words_seen, completions, errors);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d result words outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
